// ===== rtl/gtsw_pkg.sv =====
// ----------------------------------------------------------------------------
// gtsw_pkg: shared types and constants for the gate triggered stopwatch
// Word layouts for the item and result channels, phase codes, register
// indexes and the time base constants.
// ----------------------------------------------------------------------------
package gtsw_pkg;

  // timer phase
  typedef enum logic [1:0] {
    PH_ARMED   = 2'd0,
    PH_RUNNING = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

  // configuration register indexes
  localparam logic [1:0] REG_TICK_PERIOD = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE    = 2'd1;
  localparam logic [1:0] REG_IDLE_LIMIT  = 2'd2;

  // register reset values
  localparam logic [9:0]  TICK_PERIOD_RST = 10'd256;
  localparam logic [7:0]  DEBOUNCE_RST    = 8'd50;
  localparam logic [15:0] IDLE_LIMIT_RST  = 16'd60000;

  // time base
  localparam logic [10:0] US_PER_MS      = 11'd1000;
  localparam logic [10:0] US_PER_2MS     = 11'd2000;
  localparam logic [10:0] MS_PER_S       = 11'd1000;
  localparam logic [7:0]  DEBOUNCE_MAX   = 8'd255;
  localparam logic [15:0] IDLE_MAX       = 16'd65535;

  // input word
  typedef struct packed {
    logic mode;
    logic changed_sensor;
    logic sensor0_level;
    logic sensor1_level;
    logic button_level;
  } in_word_t;

  // display digits
  typedef struct packed {
    logic [3:0] digit_seconds;
    logic [3:0] digit_tenths;
    logic [3:0] digit_hundredths;
    logic [3:0] digit_thousandths;
  } digits_t;

  // result word
  typedef struct packed {
    logic [1:0] run_state;
    logic [7:0] seconds;
    logic [9:0] milliseconds;
    logic [3:0] digit_seconds;
    logic [3:0] digit_tenths;
    logic [3:0] digit_hundredths;
    logic [3:0] digit_thousandths;
    logic       beep_request;
    logic       sleep_request;
  } out_word_t;

endpackage

// ===== rtl/gtsw_digits.sv =====
// ----------------------------------------------------------------------------
// gtsw_digits: decimal digit split for the display
// Splits seconds into its ones digit and milliseconds into three decimal digits
// with reciprocal multiplies; exact for seconds below 256 and milliseconds below 1000.
// ----------------------------------------------------------------------------
module gtsw_digits (
  input  logic [7:0]       seconds,
  input  logic [9:0]       milliseconds,
  output gtsw_pkg::digits_t digits
);

  logic [15:0] ms_prod;
  logic [3:0]  ms_hund;
  logic [10:0] hund_back;
  logic [6:0]  ms_rem;
  logic [14:0] rem_prod;
  logic [3:0]  ms_tens;
  logic [7:0]  tens_back;
  logic [15:0] s_prod;
  logic [4:0]  s_tens;
  logic [7:0]  s_back;

  // milliseconds: /100 as *41 >> 12, then /10 as *205 >> 11
  always_comb begin
    ms_prod   = {6'd0, milliseconds} * 16'd41;
    ms_hund   = ms_prod[15:12];
    hund_back = {7'd0, ms_hund} * 11'd100;
    ms_rem    = 7'(milliseconds - hund_back[9:0]);
    rem_prod  = {8'd0, ms_rem} * 15'd205;
    ms_tens   = rem_prod[14:11];
    tens_back = {4'd0, ms_tens} * 8'd10;
  end

  // seconds: ones digit via *205 >> 11
  always_comb begin
    s_prod = {8'd0, seconds} * 16'd205;
    s_tens = s_prod[15:11];
    s_back = {3'd0, s_tens} * 8'd10;
  end

  assign digits.digit_seconds     = 4'(seconds - s_back);
  assign digits.digit_tenths      = ms_hund;
  assign digits.digit_hundredths  = ms_tens;
  assign digits.digit_thousandths = 4'({1'b0, ms_rem} - tens_back);

endmodule

// ===== rtl/gate_triggered_stopwatch.sv =====
// ----------------------------------------------------------------------------
// gate_triggered_stopwatch: photogate stopwatch, armed / running / stopped
// Tick words advance time and the button and idle logic; sensor words start
// and stop the count.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_word carry one tick or sensor word; each accepted
//   word yields exactly one result word on out_valid/out_ready/out_word,
//   showing the phase and time after that word.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write tick period (0), debounce
//   time (1) and idle limit (2); cfg_ready is always high, other indexes are
//   dropped. Write configuration only while no result is outstanding.
//   The result is registered: it is in the output register in the cycle after
//   acceptance. One word per cycle is sustained while out_ready is high; the
//   whole update is a single pass of add, compare and subtract logic into the state.
//   When the receiver stalls, the held result blocks a new word only if
//   out_ready stays low; in_ready = !out_valid | out_ready.
//   Reset (rst_n low, synchronous) arms the timer, clears time and counters
//   and restores register defaults (256 us, 50 ms, 60000 ms).
// ----------------------------------------------------------------------------
module gate_triggered_stopwatch (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gtsw_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output gtsw_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  // configuration
  logic [9:0]  tick_period_r;
  logic [7:0]  debounce_r;
  logic [15:0] idle_limit_r;

  // stopwatch state
  gtsw_pkg::phase_t phase_r, phase_nxt;
  logic [9:0]  micro_r, micro_nxt;
  logic [9:0]  milli_r, milli_nxt;
  logic [7:0]  second_r, second_nxt;
  logic [1:0]  div_r, div_nxt;
  logic [7:0]  deb_r, deb_nxt;
  logic        held_r, held_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic        armed_lvl_r, armed_lvl_nxt;
  logic        beep_nxt, sleep_nxt;

  // result register
  logic        out_valid_r;
  logic [1:0]  res_state_r;
  logic [7:0]  res_sec_r;
  logic [9:0]  res_ms_r;
  logic        res_beep_r;
  logic        res_sleep_r;

  gtsw_pkg::digits_t digits;

  logic accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_period_r <= gtsw_pkg::TICK_PERIOD_RST;
      debounce_r    <= gtsw_pkg::DEBOUNCE_RST;
      idle_limit_r  <= gtsw_pkg::IDLE_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gtsw_pkg::REG_TICK_PERIOD: tick_period_r <= cfg_data[9:0];
        gtsw_pkg::REG_DEBOUNCE:    debounce_r    <= cfg_data[7:0];
        gtsw_pkg::REG_IDLE_LIMIT:  idle_limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state for one word
  always_comb begin
    logic [10:0] usum;
    logic [1:0]  ms_carry;
    logic [10:0] msum;
    logic        arm;

    phase_nxt     = phase_r;
    micro_nxt     = micro_r;
    milli_nxt     = milli_r;
    second_nxt    = second_r;
    div_nxt       = div_r;
    deb_nxt       = deb_r;
    held_nxt      = held_r;
    idle_nxt      = idle_r;
    armed_lvl_nxt = armed_lvl_r;
    beep_nxt      = 1'b0;
    sleep_nxt     = 1'b0;
    arm           = 1'b0;
    usum          = {1'b0, micro_r} + {1'b0, tick_period_r};
    ms_carry      = 2'd0;
    msum          = 11'd0;

    if (!in_word.mode) begin
      // time update while running; carry can reach two milliseconds
      if (phase_r == gtsw_pkg::PH_RUNNING) begin
        priority if (usum >= gtsw_pkg::US_PER_2MS) begin
          micro_nxt = 10'(usum - gtsw_pkg::US_PER_2MS);
          ms_carry  = 2'd2;
        end else if (usum >= gtsw_pkg::US_PER_MS) begin
          micro_nxt = 10'(usum - gtsw_pkg::US_PER_MS);
          ms_carry  = 2'd1;
        end else begin
          micro_nxt = usum[9:0];
        end
        msum = {1'b0, milli_r} + {9'd0, ms_carry};
        if (msum >= gtsw_pkg::MS_PER_S) begin
          milli_nxt  = 10'(msum - gtsw_pkg::MS_PER_S);
          second_nxt = second_r + 8'd1;
        end else begin
          milli_nxt  = msum[9:0];
        end
      end

      // quarter-rate counters
      if (div_r == 2'd3) begin
        div_nxt = 2'd0;
        if (deb_r != gtsw_pkg::DEBOUNCE_MAX) deb_nxt = deb_r + 8'd1;
        if (idle_r != gtsw_pkg::IDLE_MAX) idle_nxt = idle_r + 16'd1;
      end else begin
        div_nxt = div_r + 2'd1;
      end

      // debounced button
      if (!in_word.button_level) begin
        if (!held_r && deb_nxt > debounce_r) begin
          held_nxt = 1'b1;
          deb_nxt  = 8'd0;
          beep_nxt = 1'b1;
          idle_nxt = 16'd0;
          unique case (phase_r)
            gtsw_pkg::PH_ARMED:   phase_nxt = gtsw_pkg::PH_RUNNING;
            gtsw_pkg::PH_RUNNING: phase_nxt = gtsw_pkg::PH_STOPPED;
            default:              arm = 1'b1;
          endcase
        end
      end else if (held_r && deb_nxt > debounce_r) begin
        held_nxt = 1'b0;
        deb_nxt  = 8'd0;
      end

      // idle timeout
      if (idle_nxt > idle_limit_r) begin
        arm       = 1'b1;
        sleep_nxt = 1'b1;
      end

      if (arm) begin
        phase_nxt     = gtsw_pkg::PH_ARMED;
        micro_nxt     = 10'd0;
        milli_nxt     = 10'd0;
        second_nxt    = 8'd0;
        idle_nxt      = 16'd0;
        armed_lvl_nxt = in_word.sensor0_level;
      end
    end else begin
      // sensor edge
      if (phase_r == gtsw_pkg::PH_ARMED && !in_word.changed_sensor) begin
        phase_nxt = gtsw_pkg::PH_RUNNING;
        beep_nxt  = 1'b1;
        idle_nxt  = 16'd0;
      end else if (phase_r == gtsw_pkg::PH_RUNNING && in_word.changed_sensor) begin
        if (armed_lvl_r != in_word.sensor1_level) begin
          phase_nxt = gtsw_pkg::PH_STOPPED;
          beep_nxt  = 1'b1;
        end
        idle_nxt = 16'd0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= gtsw_pkg::PH_ARMED;
      micro_r     <= 10'd0;
      milli_r     <= 10'd0;
      second_r    <= 8'd0;
      div_r       <= 2'd0;
      deb_r       <= 8'd0;
      held_r      <= 1'b0;
      idle_r      <= 16'd0;
      armed_lvl_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      micro_r     <= micro_nxt;
      milli_r     <= milli_nxt;
      second_r    <= second_nxt;
      div_r       <= div_nxt;
      deb_r       <= deb_nxt;
      held_r      <= held_nxt;
      idle_r      <= idle_nxt;
      armed_lvl_r <= armed_lvl_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_state_r <= phase_nxt;
      res_sec_r   <= second_nxt;
      res_ms_r    <= milli_nxt;
      res_beep_r  <= beep_nxt;
      res_sleep_r <= sleep_nxt;
    end
  end

  gtsw_digits u_digits (
    .seconds      (res_sec_r),
    .milliseconds (res_ms_r),
    .digits       (digits)
  );

  // result word
  always_comb begin
    out_word.run_state         = res_state_r;
    out_word.seconds           = res_sec_r;
    out_word.milliseconds      = res_ms_r;
    out_word.digit_seconds     = digits.digit_seconds;
    out_word.digit_tenths      = digits.digit_tenths;
    out_word.digit_hundredths  = digits.digit_hundredths;
    out_word.digit_thousandths = digits.digit_thousandths;
    out_word.beep_request      = res_beep_r;
    out_word.sleep_request     = res_sleep_r;
  end

  assign out_valid = out_valid_r;

  // checks
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    micro_r < 10'd1000 && milli_r < 10'd1000)
    else $error("time counters out of range");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word produced no result");

  a_sleep_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_sleep_r |-> res_state_r == gtsw_pkg::PH_ARMED
      && res_sec_r == 8'd0 && res_ms_r == 10'd0)
    else $error("sleep without re-arm");

endmodule

// ===== tb/sv/gate_triggered_stopwatch_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gate_triggered_stopwatch_test: self-checking bench for the photogate timer
// Drives tick and sensor words through the valid/ready input, rewrites the
// three timing registers between phases and compares every result word with
// a cycle-free model of the armed / running / stopped timer held in a small
// scoreboard. A directed opening walks the gate, button and idle paths; the
// rest is random words under several register settings.
// ----------------------------------------------------------------------------
module gate_triggered_stopwatch_test;

  // word field codes
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_SENSOR = 1'b1;
  localparam logic GATE_START  = 1'b0;
  localparam logic GATE_STOP   = 1'b1;
  localparam logic BTN_DOWN    = 1'b0;
  localparam logic BTN_UP      = 1'b1;
  // index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int unsigned NUM_SETTINGS    = 7;
  localparam int unsigned WORDS_PER_SET   = 160;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;

  // register settings per random phase
  localparam logic [9:0]  SET_PERIOD [NUM_SETTINGS] =
    '{10'd1, 10'd1023, 10'd0, 10'd500, 10'd37, 10'd999, 10'd256};
  localparam logic [7:0]  SET_DEBOUNCE [NUM_SETTINGS] =
    '{8'd1, 8'd2, 8'd255, 8'd3, 8'd0, 8'd254, 8'd50};
  localparam logic [15:0] SET_IDLE [NUM_SETTINGS] =
    '{16'd8, 16'd40, 16'd0, 16'd65534, 16'd3, 16'd65535, 16'd60000};

  // --------------------------------------------------------------------------
  // Scoreboard: timer model and queue of expected result words
  // --------------------------------------------------------------------------
  class stopwatch_scoreboard;
    int unsigned          tick_period_us;
    int unsigned          debounce_ms;
    int unsigned          idle_limit_ms;
    gtsw_pkg::phase_t     phase;
    int unsigned          micro_us;
    int unsigned          milli_ms;
    int unsigned          secs;
    int unsigned          tick_div;
    int unsigned          debounce_cnt;
    int unsigned          idle_cnt;
    bit                   button_held;
    bit                   armed_level;
    gtsw_pkg::out_word_t  expected_q[$];
    int unsigned          errors;

    function new();
      tick_period_us = 32'(gtsw_pkg::TICK_PERIOD_RST);
      debounce_ms    = 32'(gtsw_pkg::DEBOUNCE_RST);
      idle_limit_ms  = 32'(gtsw_pkg::IDLE_LIMIT_RST);
      phase          = gtsw_pkg::PH_ARMED;
      micro_us       = 0;
      milli_ms       = 0;
      secs           = 0;
      tick_div       = 0;
      debounce_cnt   = 0;
      idle_cnt       = 0;
      button_held    = 0;
      armed_level    = 0;
      errors         = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        gtsw_pkg::REG_TICK_PERIOD: tick_period_us = 32'(data[9:0]);
        gtsw_pkg::REG_DEBOUNCE:    debounce_ms = 32'(data[7:0]);
        gtsw_pkg::REG_IDLE_LIMIT:  idle_limit_ms = 32'(data);
        default: ;
      endcase
    endfunction

    // back to armed: time cleared, gate level latched
    function void rearm(logic s0);
      phase       = gtsw_pkg::PH_ARMED;
      micro_us    = 0;
      milli_ms    = 0;
      secs        = 0;
      idle_cnt    = 0;
      armed_level = s0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // one accepted input word -> one expected result word
    function void note_word(gtsw_pkg::in_word_t w);
      gtsw_pkg::out_word_t want;
      int unsigned         us_sum;
      int unsigned         ms_sum;
      bit                  beep;
      bit                  slp;
      beep = 0;
      slp  = 0;
      if (w.mode == MODE_TICK) begin
        // time first, then quarter-rate counters, button, idle
        if (phase == gtsw_pkg::PH_RUNNING) begin
          us_sum   = micro_us + tick_period_us;
          ms_sum   = milli_ms + us_sum / 1000;
          secs     = (secs + ms_sum / 1000) % 256;
          micro_us = us_sum % 1000;
          milli_ms = ms_sum % 1000;
        end
        tick_div++;
        if (tick_div >= 4) begin
          tick_div = 0;
          if (debounce_cnt < 255) debounce_cnt++;
          if (idle_cnt < 65535) idle_cnt++;
        end
        if (w.button_level == BTN_DOWN) begin
          if (!button_held && debounce_cnt > debounce_ms) begin
            button_held  = 1;
            debounce_cnt = 0;
            if (phase == gtsw_pkg::PH_STOPPED) rearm(w.sensor0_level);
            else phase = gtsw_pkg::phase_t'(phase + 2'd1);
            idle_cnt = 0;
            beep     = 1;
          end
        end else if (button_held && debounce_cnt > debounce_ms) begin
          button_held  = 0;
          debounce_cnt = 0;
        end
        if (idle_cnt > idle_limit_ms) begin
          rearm(w.sensor0_level);
          slp = 1;
        end
      end else if (phase == gtsw_pkg::PH_ARMED && w.changed_sensor == GATE_START) begin
        phase    = gtsw_pkg::PH_RUNNING;
        beep     = 1;
        idle_cnt = 0;
      end else if (phase == gtsw_pkg::PH_RUNNING && w.changed_sensor == GATE_STOP) begin
        // only a level away from the armed one stops the count
        if (w.sensor1_level != armed_level) begin
          phase = gtsw_pkg::PH_STOPPED;
          beep  = 1;
        end
        idle_cnt = 0;
      end
      want.run_state         = phase;
      want.seconds           = secs[7:0];
      want.milliseconds      = milli_ms[9:0];
      want.digit_seconds     = 4'(secs % 10);
      want.digit_tenths      = 4'(milli_ms / 100);
      want.digit_hundredths  = 4'((milli_ms % 100) / 10);
      want.digit_thousandths = 4'(milli_ms % 10);
      want.beep_request      = beep;
      want.sleep_request     = slp;
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(gtsw_pkg::out_word_t got);
      gtsw_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("run_state", 16'(want.run_state), 16'(got.run_state));
      compare_field("seconds", 16'(want.seconds), 16'(got.seconds));
      compare_field("milliseconds", 16'(want.milliseconds), 16'(got.milliseconds));
      compare_field("digit_seconds", 16'(want.digit_seconds), 16'(got.digit_seconds));
      compare_field("digit_tenths", 16'(want.digit_tenths), 16'(got.digit_tenths));
      compare_field("digit_hundredths", 16'(want.digit_hundredths),
                    16'(got.digit_hundredths));
      compare_field("digit_thousandths", 16'(want.digit_thousandths),
                    16'(got.digit_thousandths));
      compare_field("beep_request", 16'(want.beep_request), 16'(got.beep_request));
      compare_field("sleep_request", 16'(want.sleep_request), 16'(got.sleep_request));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and clock
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  gtsw_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_ready;
  gtsw_pkg::out_word_t out_word;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [15:0]         cfg_data;

  stopwatch_scoreboard sb;
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 8;
  bit          hold_off_req  = 1'b0;
  logic        btn_level     = BTN_UP;

  gate_triggered_stopwatch i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic gtsw_pkg::in_word_t make_word(logic mode, logic gate, logic s0,
                                                   logic s1, logic btn);
    gtsw_pkg::in_word_t w;
    w.mode           = mode;
    w.changed_sensor = gate;
    w.sensor0_level  = s0;
    w.sensor1_level  = s1;
    w.button_level   = btn;
    return w;
  endfunction

  // mostly ticks; button held in runs so that debounce can settle
  function automatic gtsw_pkg::in_word_t random_word();
    gtsw_pkg::in_word_t w;
    w = gtsw_pkg::in_word_t'(5'($urandom));
    if ($urandom_range(99) < 75) begin
      w.mode = MODE_TICK;
      if ($urandom_range(7) == 0) btn_level = ~btn_level;
      w.button_level = btn_level;
    end else begin
      w.mode = MODE_SENSOR;
    end
    return w;
  endfunction

  task automatic send_word(input gtsw_pkg::in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // all three registers plus the unused index; junk in the unused upper bits
  task automatic write_regs(input logic [9:0] period, input logic [7:0] deb,
                            input logic [15:0] limit);
    logic [15:0] data [4];
    int          i;
    data[gtsw_pkg::REG_TICK_PERIOD] = {6'($urandom), period};
    data[gtsw_pkg::REG_DEBOUNCE]    = {8'($urandom), deb};
    data[gtsw_pkg::REG_IDLE_LIMIT]  = limit;
    data[REG_UNUSED]                = 16'($urandom);
    for (i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= data[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(2'(i), data[i]);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_word);
  end

  // watchdog on cycles with no word moving anywhere
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned set;
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = gtsw_pkg::REG_TICK_PERIOD;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: long period for carries, no debounce, tight idle limit
    settle();
    write_regs(10'd999, 8'd0, 16'd2);
    send_word(make_word(MODE_SENSOR, GATE_STOP, 1'b1, 1'b1, BTN_UP));  // stop gate, armed
    send_word(make_word(MODE_SENSOR, GATE_START, 1'b1, 1'b0, BTN_UP)); // start
    repeat (4) send_word(make_word(MODE_TICK, GATE_START, 1'b0, 1'b0, BTN_UP));
    send_word(make_word(MODE_SENSOR, GATE_START, 1'b0, 1'b0, BTN_UP)); // start gate, running
    send_word(make_word(MODE_SENSOR, GATE_STOP, 1'b0, 1'b0, BTN_UP));  // same level: runs on
    send_word(make_word(MODE_SENSOR, GATE_STOP, 1'b0, 1'b1, BTN_UP));  // stop
    send_word(make_word(MODE_SENSOR, GATE_START, 1'b1, 1'b1, BTN_UP)); // stopped: ignored
    // press re-arms with gate high, hold, release, then idle until sleep
    send_word(make_word(MODE_TICK, GATE_STOP, 1'b1, 1'b1, BTN_DOWN));
    repeat (3) send_word(make_word(MODE_TICK, GATE_STOP, 1'b1, 1'b1, BTN_DOWN));
    repeat (11) send_word(make_word(MODE_TICK, GATE_START, 1'b1, 1'b0, BTN_UP));

    // random phases
    for (set = 0; set < NUM_SETTINGS; set++) begin
      settle();
      write_regs(SET_PERIOD[set], SET_DEBOUNCE[set], SET_IDLE[set]);
      send_idle_pct = (set == 3) ? 0 : 8;
      recv_idle_pct = (set == 3) ? 0 : 8;
      if (set == 1) hold_off_req = 1'b1;
      repeat (WORDS_PER_SET) send_word(random_word());
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gtsw_pkg.sv
rtl/gtsw_digits.sv
rtl/gate_triggered_stopwatch.sv
tb/sv/gate_triggered_stopwatch_test.sv
